// ===== rtl/assert_macros.svh =====
// ---------------------------------------------------------------------------
// assert_macros.svh
// Clocked assertion helpers for the RTL. Define ASSERT_OFF to remove them.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF

// Check a condition at every clock edge outside reset.
`define ASSERT_ALWAYS(label, expr, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (expr)) \
        else $error(msg);

// Check that a condition holds in the same cycle as a trigger.
`define ASSERT_IMPLY(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |-> (cons)) else $error(msg);

// Check that a condition holds in the cycle after a trigger.
`define ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |=> (cons)) else $error(msg);

`else

`define ASSERT_ALWAYS(label, expr, msg)
`define ASSERT_IMPLY(label, ante, cons, msg)
`define ASSERT_NEXT(label, ante, cons, msg)

`endif

`endif

// ===== rtl/ipap_pkg.sv =====
// ---------------------------------------------------------------------------
// ipap_pkg
// Shared codes, widths and character helpers of the address text parser.
// ---------------------------------------------------------------------------
package ipap_pkg;

    localparam int unsigned GROUP_W     = 16;
    localparam int unsigned NUM_GROUPS  = 8;
    localparam int unsigned OCTET_MAX   = 255;
    localparam int unsigned GIDX_W      = 4;
    localparam int unsigned DCNT_W      = 3;
    localparam int unsigned HEX_DIGITS  = 4;
    localparam int unsigned V4_DOTS     = 3;

    typedef enum logic [1:0] {
        ST_OK     = 2'd0,
        ST_BAD    = 2'd1,
        ST_FAMILY = 2'd2
    } t_status;

    localparam logic [1:0] FAM_V4 = 2'd0;
    localparam logic [1:0] FAM_V6 = 2'd1;

    localparam logic [7:0] CH_DOT   = 8'h2E;
    localparam logic [7:0] CH_COLON = 8'h3A;

    typedef logic [GROUP_W-1:0] t_group;

    // Decimal digit: valid flag in bit 4, value in bits 3..0.
    function automatic logic [4:0] dec_digit(input logic [7:0] c);
        logic [4:0] r;
        r = 5'd0;
        if (c >= 8'h30 && c <= 8'h39) begin
            r = {1'b1, 4'(c - 8'h30)};
        end
        return r;
    endfunction

    // Hex digit of either case: valid flag in bit 4, value in bits 3..0.
    function automatic logic [4:0] hex_digit(input logic [7:0] c);
        logic [4:0] r;
        r = 5'd0;
        if (c >= 8'h30 && c <= 8'h39) begin
            r = {1'b1, 4'(c - 8'h30)};
        end else if (c >= 8'h61 && c <= 8'h66) begin
            r = {1'b1, 4'(c - 8'h57)};
        end else if (c >= 8'h41 && c <= 8'h46) begin
            r = {1'b1, 4'(c - 8'h37)};
        end
        return r;
    endfunction

endpackage

// ===== rtl/ip_address_text_parser.sv =====
// Stages: an accepted character is registered in the input stage and parsed
//   there; the result of a final character then enters the output register.
// Throughput: one character per cycle while the input stage is not stalled;
//   parse state is updated in one pass. Only a final character whose result
//   cannot enter a stalled output register holds the input stage; other characters flow on regardless of the output.
// Reset (synchronous, active low) empties both stages and returns the parser
//   to the start of a text.
`include "assert_macros.svh"

// ---------------------------------------------------------------------------
// ip_address_text_parser
// Streaming IPv4 / IPv6 text-to-binary address parser, one character a word.
// ---------------------------------------------------------------------------
module ip_address_text_parser (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    // character channel
    input  logic                    i_in_valid,
    output logic                    o_in_stall,
    input  logic [1:0]              i_family,
    input  logic [7:0]              i_text_char,
    input  logic                    i_is_final,
    // result channel
    output logic                    o_out_valid,
    input  logic                    i_out_stall,
    output logic [1:0]              o_status,
    output logic [63:0]             o_address_high,
    output logic [63:0]             o_address_low
);
    import ipap_pkg::*;

    // ---------------- input register ----------------
    logic                    r_in_valid;
    logic [1:0]              r_family;
    logic [7:0]              r_char;
    logic                    r_final;

    // ---------------- parse state ----------------
    t_group                  r_store [NUM_GROUPS];
    t_group                  r_acc;
    logic [DCNT_W-1:0]       r_dcnt;
    logic [GIDX_W-1:0]       r_gidx;
    logic [GIDX_W-1:0]       r_gpos;
    logic                    r_gap;
    logic                    r_colon;
    logic                    r_err;
    logic                    r_start;
    logic [1:0]              r_fam_latch;

    t_group                  n_store [NUM_GROUPS];
    t_group                  n_acc;
    logic [DCNT_W-1:0]       n_dcnt;
    logic [GIDX_W-1:0]       n_gidx;
    logic [GIDX_W-1:0]       n_gpos;
    logic                    n_gap;
    logic                    n_colon;
    logic                    n_err;
    logic [1:0]              n_fam;

    // ---------------- result register ----------------
    logic                    r_out_valid;
    logic [1:0]              r_status;
    logic [63:0]             r_addr_hi;
    logic [63:0]             r_addr_lo;

    logic [1:0]              n_status;
    logic [63:0]             n_addr_hi;
    logic [63:0]             n_addr_lo;

    // ---------------- handshake ----------------
    logic                    advance;
    logic                    in_accept;
    logic                    finish;

    // Consume the registered character unless it is a final one whose result
    // would land on a full, stalled output register.
    assign advance   = r_in_valid && (!r_final || !r_out_valid || !i_out_stall);
    assign o_in_stall = r_in_valid && !advance;
    assign in_accept = i_in_valid && !o_in_stall;
    assign finish    = advance && r_final;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (in_accept) begin
            r_in_valid <= 1'b1;
        end else if (advance) begin
            r_in_valid <= 1'b0;
        end
    end

    // Payload of the input stage: load on accept, hold otherwise.
    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_family <= i_family;
            r_char   <= i_text_char;
            r_final  <= i_is_final;
        end
    end

    // ---------------- character step and finish ----------------
    always_comb begin
        logic [4:0]         dd;
        logic [4:0]         hd;
        logic [11:0]        v4_val;
        logic               do_push;
        t_group             fst [NUM_GROUPS];
        logic [GIDX_W-1:0]  fgi;
        logic               ok;
        t_group             g [NUM_GROUPS];
        logic [4:0]         tail_pos;
        logic [4:0]         tail_lim;

        dd       = dec_digit(r_char);
        hd       = hex_digit(r_char);
        v4_val   = 12'(r_acc[7:0]) * 12'd10 + 12'(dd[3:0]);
        do_push  = 1'b0;
        tail_pos = '0;
        tail_lim = '0;

        // Sample the family on the first character of a text.
        n_fam   = r_start ? r_family : r_fam_latch;
        n_store = r_store;
        n_acc   = r_acc;
        n_dcnt  = r_dcnt;
        n_gidx  = r_gidx;
        n_gpos  = r_gpos;
        n_gap   = r_gap;
        n_colon = r_colon;
        n_err   = r_err;

        if (!r_err) begin
            if (n_fam == FAM_V4) begin
                if (dd[4]) begin
                    // Reject leading zeros and octets above 255.
                    if ((r_dcnt != '0 && r_acc == '0) || v4_val > 12'(OCTET_MAX)) begin
                        n_err = 1'b1;
                    end else begin
                        n_acc  = GROUP_W'(v4_val);
                        n_dcnt = r_dcnt + 1'b1;
                    end
                end else if (r_char == CH_DOT) begin
                    if (r_dcnt == '0 || r_gidx >= GIDX_W'(V4_DOTS)) begin
                        n_err = 1'b1;
                    end else begin
                        do_push = 1'b1;
                    end
                end else begin
                    n_err = 1'b1;
                end
            end else if (n_fam == FAM_V6) begin
                if (hd[4]) begin
                    if (r_colon && !r_gap && r_gidx == '0) begin
                        n_err = 1'b1;   // single leading colon
                    end else if (r_dcnt >= DCNT_W'(HEX_DIGITS)) begin
                        n_err = 1'b1;
                    end else begin
                        n_acc   = {r_acc[GROUP_W-5:0], hd[3:0]};
                        n_dcnt  = r_dcnt + 1'b1;
                        n_colon = 1'b0;
                    end
                end else if (r_char == CH_COLON) begin
                    if (r_dcnt != '0) begin
                        do_push = 1'b1;
                        n_colon = 1'b1;
                    end else if (r_colon) begin
                        if (r_gap) begin
                            n_err = 1'b1;
                        end else begin
                            n_gap  = 1'b1;
                            n_gpos = r_gidx;
                        end
                    end else begin
                        n_colon = 1'b1;
                    end
                end else begin
                    n_err = 1'b1;
                end
            end
        end

        // Close the current field into the group store.
        if (do_push) begin
            if (r_gidx >= GIDX_W'(NUM_GROUPS)) begin
                n_err = 1'b1;
            end else begin
                n_store[r_gidx[2:0]] = r_acc;
                n_gidx = r_gidx + 1'b1;
                n_acc  = '0;
                n_dcnt = '0;
            end
        end

        // End of text: close the open field and build the address.
        fst = n_store;
        fgi = n_gidx;
        ok  = 1'b0;
        if (n_dcnt != '0 && n_gidx < GIDX_W'(NUM_GROUPS)) begin
            fst[n_gidx[2:0]] = n_acc;
            fgi = n_gidx + 1'b1;
        end

        n_addr_hi = '0;
        n_addr_lo = '0;
        g = fst;

        if (n_fam == FAM_V4) begin
            ok = (n_dcnt != '0) && (n_gidx == GIDX_W'(V4_DOTS));
            n_addr_lo = {32'd0, fst[0][7:0], fst[1][7:0], fst[2][7:0], fst[3][7:0]};
        end else begin
            if (n_dcnt != '0) begin
                ok = n_gidx < GIDX_W'(NUM_GROUPS);
            end else begin
                ok = n_colon && n_gap && (n_gpos == n_gidx);
            end
            if (n_gap) begin
                if (fgi >= GIDX_W'(NUM_GROUPS) || n_gpos > fgi) begin
                    ok = 1'b0;
                end
                // Groups before the gap stay; the tail moves to the end.
                for (int k = 0; k < NUM_GROUPS; k++) begin
                    tail_pos = 5'(k) + 5'(fgi);
                    tail_lim = 5'(NUM_GROUPS) + 5'(n_gpos);
                    if (GIDX_W'(k) < n_gpos) begin
                        g[k] = fst[k];
                    end else if (tail_pos >= tail_lim) begin
                        g[k] = fst[tail_pos[2:0]];
                    end else begin
                        g[k] = '0;
                    end
                end
            end else if (fgi != GIDX_W'(NUM_GROUPS)) begin
                ok = 1'b0;
            end
            n_addr_hi = {g[0], g[1], g[2], g[3]};
            n_addr_lo = {g[4], g[5], g[6], g[7]};
        end

        if (n_fam != FAM_V4 && n_fam != FAM_V6) begin
            n_status = ST_FAMILY;
        end else if (n_err || !ok) begin
            n_status = ST_BAD;
        end else begin
            n_status = ST_OK;
        end
        if (n_status != ST_OK) begin
            n_addr_hi = '0;
            n_addr_lo = '0;
        end
    end

    // Control state: clear on reset and at the end of every text. The group
    // store needs no clear: only entries written since the last text are read.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_acc       <= '0;
            r_dcnt      <= '0;
            r_gidx      <= '0;
            r_gpos      <= '0;
            r_gap       <= 1'b0;
            r_colon     <= 1'b0;
            r_err       <= 1'b0;
            r_start     <= 1'b1;
            r_fam_latch <= FAM_V4;
        end else if (advance) begin
            if (r_final) begin
                r_acc       <= '0;
                r_dcnt      <= '0;
                r_gidx      <= '0;
                r_gpos      <= '0;
                r_gap       <= 1'b0;
                r_colon     <= 1'b0;
                r_err       <= 1'b0;
                r_start     <= 1'b1;
                r_fam_latch <= FAM_V4;
            end else begin
                r_acc       <= n_acc;
                r_dcnt      <= n_dcnt;
                r_gidx      <= n_gidx;
                r_gpos      <= n_gpos;
                r_gap       <= n_gap;
                r_colon     <= n_colon;
                r_err       <= n_err;
                r_start     <= 1'b0;
                r_fam_latch <= n_fam;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance && !r_final) begin
            r_store <= n_store;
        end
    end

    // ---------------- output register ----------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (finish) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (finish) begin
            r_status  <= n_status;
            r_addr_hi <= n_addr_hi;
            r_addr_lo <= n_addr_lo;
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_status       = r_status;
    assign o_address_high = r_addr_hi;
    assign o_address_low  = r_addr_lo;

    // ---------------- assertions ----------------
    `ASSERT_IMPLY(a_bad_zero_addr, r_out_valid && r_status != ST_OK,
        r_addr_hi == '0 && r_addr_lo == '0, "failed result carries a nonzero address")
    `ASSERT_NEXT(a_final_restarts, finish, r_start && !r_err && r_gidx == '0,
        "parse state not cleared after final character")
    `ASSERT_ALWAYS(a_gidx_range, r_gidx <= GIDX_W'(NUM_GROUPS),
        "group index beyond store depth")
    `ASSERT_ALWAYS(a_dcnt_range, r_dcnt <= DCNT_W'(HEX_DIGITS), "digit count beyond four")
    `ASSERT_IMPLY(a_stall_only_final, o_in_stall, r_in_valid && r_final && r_out_valid,
        "input stalled without a blocked final character")

endmodule

// ===== sim/tb_top.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tb_top
// Self-checking bench for the address text parser: streams IPv4, IPv6,
// unsupported-family and junk texts one character a word, predicts each
// final-character result in a scoreboard class and compares every field.
// ---------------------------------------------------------------------------
module tb_top;
    import ipap_pkg::*;

    localparam int unsigned IDLE_LIMIT   = 2000; // cycles with no word moved
    localparam int unsigned DRAIN_CYCLES = 8;    // settle time after last result
    localparam int unsigned CHAR_TARGET  = 750;  // characters to send in all
    localparam logic [1:0]  FAM_OTHER    = 2'd2; // unsupported families
    localparam logic [1:0]  FAM_SPARE    = 2'd3;

    typedef logic [7:0] t_text[$];

    typedef struct {
        t_status     st;
        logic [63:0] hi;
        logic [63:0] lo;
    } t_addr_result;

    // -----------------------------------------------------------------------
    // Scoreboard: own copy of the parse state, and the addresses still owed
    // by the block, oldest first.
    // -----------------------------------------------------------------------
    class addr_parse_model;
        t_group       grp[NUM_GROUPS];
        logic [15:0]  acc;
        logic [2:0]   ndig;
        logic [3:0]   gidx;
        logic [3:0]   gap_at;
        bit           gap_seen;
        bit           prev_colon;
        bit           bad;
        bit           fresh;
        logic [1:0]   fam;
        t_addr_result pending_addr[$];
        int           mismatches;
        int           results_seen;

        function new();
            mismatches   = 0;
            results_seen = 0;
            restart();
        endfunction

        // Return to the start of a text.
        function void restart();
            foreach (grp[i]) grp[i] = '0;
            acc        = '0;
            ndig       = '0;
            gidx       = '0;
            gap_at     = '0;
            gap_seen   = 1'b0;
            prev_colon = 1'b0;
            bad        = 1'b0;
            fresh      = 1'b1;
            fam        = FAM_V4;
        endfunction

        function int waiting();
            return pending_addr.size();
        endfunction

        function int nibble_of(logic [7:0] c);
            if (c >= "0" && c <= "9") return int'(c) - int'("0");
            if (c >= "a" && c <= "f") return int'(c) - int'("a") + 10;
            if (c >= "A" && c <= "F") return int'(c) - int'("A") + 10;
            return -1;
        endfunction

        // Close the current field into the group store; a ninth group is an error.
        function void push_field();
            if (gidx >= 4'(NUM_GROUPS)) begin
                bad = 1'b1;
                return;
            end
            grp[gidx[2:0]] = acc;
            gidx++;
            acc  = '0;
            ndig = '0;
        endfunction

        function void take_v4(logic [7:0] c);
            int v;
            if (c >= "0" && c <= "9") begin
                v = int'(acc) * 10 + int'(c) - int'("0");
                // leading zero or octet overflow
                if ((ndig != 0 && acc == 0) || v > int'(OCTET_MAX)) begin
                    bad = 1'b1;
                    return;
                end
                acc = 16'(v);
                ndig++;
            end else if (c == CH_DOT) begin
                if (ndig == 0 || gidx >= 4'(V4_DOTS)) begin
                    bad = 1'b1;
                    return;
                end
                push_field();
            end else begin
                bad = 1'b1;
            end
        endfunction

        function void take_v6(logic [7:0] c);
            int h;
            h = nibble_of(c);
            if (h >= 0) begin
                // a single colon at the head of the text
                if (prev_colon && !gap_seen && gidx == 0) begin
                    bad = 1'b1;
                    return;
                end
                if (ndig >= 3'(HEX_DIGITS)) begin
                    bad = 1'b1;
                    return;
                end
                acc = {acc[11:0], 4'(h)};
                ndig++;
                prev_colon = 1'b0;
            end else if (c == CH_COLON) begin
                if (ndig != 0) begin
                    push_field();
                    prev_colon = 1'b1;
                end else if (prev_colon) begin
                    // second colon in a row opens the gap; only one allowed
                    if (gap_seen) begin
                        bad = 1'b1;
                        return;
                    end
                    gap_seen = 1'b1;
                    gap_at   = gidx;
                end else begin
                    prev_colon = 1'b1;
                end
            end else begin
                bad = 1'b1;
            end
        endfunction

        function bit close_v4(output logic [63:0] lo);
            lo = '0;
            if (ndig == 0 || gidx != 4'(V4_DOTS)) return 1'b0;
            push_field();
            lo = {32'd0, grp[0][7:0], grp[1][7:0], grp[2][7:0], grp[3][7:0]};
            return 1'b1;
        endfunction

        function bit close_v6(output logic [63:0] hi, output logic [63:0] lo);
            t_group g[NUM_GROUPS];
            int     tail;
            hi = '0;
            lo = '0;
            if (ndig != 0) begin
                push_field();
                if (bad) return 1'b0;
            end else if (prev_colon) begin
                // a trailing colon is fine only as the end of "::"
                if (!(gap_seen && gap_at == gidx)) return 1'b0;
            end else begin
                return 1'b0;
            end
            foreach (g[i]) g[i] = '0;
            if (gap_seen) begin
                if (gidx >= 4'(NUM_GROUPS) || gap_at > gidx) return 1'b0;
                tail = int'(gidx) - int'(gap_at);
                for (int i = 0; i < int'(gap_at); i++) g[i] = grp[i];
                // groups after the gap move to the end of the address
                for (int i = 0; i < tail; i++) g[8 - tail + i] = grp[int'(gap_at) + i];
            end else begin
                if (gidx != 4'(NUM_GROUPS)) return 1'b0;
                g = grp;
            end
            hi = {g[0], g[1], g[2], g[3]};
            lo = {g[4], g[5], g[6], g[7]};
            return 1'b1;
        endfunction

        // Note one accepted character; a final character owes one address.
        function void accept_char(logic [1:0] fam_in, logic [7:0] c, logic fin);
            t_addr_result r;
            bit           ok;
            if (fresh) begin
                fam   = fam_in;
                fresh = 1'b0;
            end
            if (!bad) begin
                if (fam == FAM_V4) take_v4(c);
                else if (fam == FAM_V6) take_v6(c);
            end
            if (!fin) return;
            r.hi = '0;
            r.lo = '0;
            if (fam > FAM_V6) begin
                r.st = ST_FAMILY;
            end else if (bad) begin
                r.st = ST_BAD;
            end else begin
                if (fam == FAM_V4) ok = close_v4(r.lo);
                else ok = close_v6(r.hi, r.lo);
                r.st = (ok && !bad) ? ST_OK : ST_BAD;
            end
            if (r.st != ST_OK) begin
                r.hi = '0;
                r.lo = '0;
            end
            pending_addr.push_back(r);
            restart();
        endfunction

        function void flag(string what, logic [63:0] want, logic [63:0] got);
            mismatches++;
            if (mismatches <= 10)
                $display("result %0d %s: expected %h, got %h", results_seen, what, want, got);
        endfunction

        function void check_result(t_status st, logic [63:0] hi, logic [63:0] lo);
            t_addr_result r;
            results_seen++;
            if (pending_addr.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("result %0d arrived with no text pending, status %0d",
                             results_seen, st);
                return;
            end
            r = pending_addr.pop_front();
            if (st !== r.st) flag("status", 64'(r.st), 64'(st));
            if (hi !== r.hi) flag("address_high", r.hi, hi);
            if (lo !== r.lo) flag("address_low", r.lo, lo);
        endfunction

        // Anything still owed at the end is a failure.
        function void close();
            if (pending_addr.size() != 0) begin
                mismatches += pending_addr.size();
                $display("%0d texts never produced a result", pending_addr.size());
            end
        endfunction
    endclass

    // -----------------------------------------------------------------------
    // Clock, reset and block inputs; every input is known from time zero.
    // -----------------------------------------------------------------------
    logic        i_clk;
    logic        i_rst_n       = 1'b0;
    logic        i_in_valid    = 1'b0;
    logic [1:0]  i_family      = FAM_V4;
    logic [7:0]  i_text_char   = 8'd0;
    logic        i_is_final    = 1'b0;
    logic        i_out_stall   = 1'b0;
    logic        o_in_stall;
    logic        o_out_valid;
    logic [1:0]  o_status;
    logic [63:0] o_address_high;
    logic [63:0] o_address_low;

    addr_parse_model sb;
    bit              quiet         = 1'b0; // no idling on either side
    int unsigned     counted_chars = 0;
    int unsigned     hold_left     = 0;
    int unsigned     idle_cycles   = 0;

    ip_address_text_parser dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .o_in_stall     (o_in_stall),
        .i_family       (i_family),
        .i_text_char    (i_text_char),
        .i_is_final     (i_is_final),
        .o_out_valid    (o_out_valid),
        .i_out_stall    (i_out_stall),
        .o_status       (o_status),
        .o_address_high (o_address_high),
        .o_address_low  (o_address_low)
    );

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    // Sample both channels at the edge, before any driver update lands.
    // Note the input word first so a result never races its own text.
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_in_valid && !o_in_stall)
                sb.accept_char(i_family, i_text_char, i_is_final);
            if (o_out_valid && !i_out_stall)
                sb.check_result(t_status'(o_status), o_address_high, o_address_low);
        end
    end

    // Result side: after each accepted word, hold stall for a random count.
    always @(posedge i_clk) begin
        if (o_out_valid && !i_out_stall) begin
            hold_left = quiet ? 0 : $urandom_range(0, 7);
        end else if (hold_left != 0) begin
            hold_left--;
        end
        i_out_stall <= (hold_left != 0);
    end

    // Watchdog: end the run if no word moves on either channel for too long.
    always @(posedge i_clk) begin
        if (!i_rst_n || (i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= IDLE_LIMIT) begin
            $display("[ip_address_text_parser] ERROR");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    // -----------------------------------------------------------------------
    // Drivers
    // -----------------------------------------------------------------------

    // Idle for a random gap, then present one word and hold it until taken.
    task automatic send_char(input logic [1:0] fam, input logic [7:0] c, input logic fin);
        int gap;
        gap = quiet ? 0 : $urandom_range(0, 7);
        repeat (gap) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid  <= 1'b1;
        i_family    <= fam;
        i_text_char <= c;
        i_is_final  <= fin;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
    endtask

    // Send a whole text; the family only counts on the first character, so
    // scramble it on the rest.
    task automatic send_text(input logic [1:0] fam, input t_text txt);
        if (txt.size() == 0) txt.push_back("0");
        for (int i = 0; i < txt.size(); i++)
            send_char((i == 0) ? fam : 2'($urandom_range(0, 3)), txt[i],
                      i == txt.size() - 1);
        counted_chars += txt.size();
    endtask

    // Drop valid and hold off until every owed address has come back.
    task automatic drain_results();
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (sb.waiting() != 0) @(posedge i_clk);
    endtask

    // -----------------------------------------------------------------------
    // Text builders
    // -----------------------------------------------------------------------
    function automatic t_text from_str(string s);
        t_text t;
        for (int i = 0; i < s.len(); i++) t.push_back(s[i]);
        return t;
    endfunction

    function automatic int pick_octet();
        case ($urandom_range(0, 3))
            0:       return 0;
            1:       return 255;
            default: return $urandom_range(0, 255);
        endcase
    endfunction

    function automatic t_text make_v4();
        return from_str($sformatf("%0d.%0d.%0d.%0d", pick_octet(), pick_octet(),
                                  pick_octet(), pick_octet()));
    endfunction

    // One hex group of one to four digits, mixed case, leading zeros allowed.
    function automatic void add_group(ref t_text t);
        int n;
        int v;
        n = $urandom_range(1, 4);
        repeat (n) begin
            v = $urandom_range(0, 15);
            if (v < 10) t.push_back(8'("0" + v));
            else if ($urandom_range(0, 1)) t.push_back(8'("A" + v - 10));
            else t.push_back(8'("a" + v - 10));
        end
    endfunction

    // Eight explicit groups, or fewer around one "::".
    function automatic t_text make_v6();
        t_text t;
        int    lead;
        int    tail;
        bit    gapped;
        gapped = $urandom_range(0, 1);
        if (gapped) begin
            lead = $urandom_range(0, 7);
            tail = $urandom_range(0, 7 - lead);
        end else begin
            lead = 8;
            tail = 0;
        end
        for (int i = 0; i < lead; i++) begin
            if (i > 0) t.push_back(CH_COLON);
            add_group(t);
        end
        if (gapped) begin
            t.push_back(CH_COLON);
            t.push_back(CH_COLON);
            for (int i = 0; i < tail; i++) begin
                if (i > 0) t.push_back(CH_COLON);
                add_group(t);
            end
        end
        return t;
    endfunction

    // Break a well-formed text: overwrite, insert or drop one character, or append a group.
    function automatic t_text mutate(t_text t);
        int  pos;
        byte pick;
        pos = $urandom_range(0, t.size() - 1);
        case ($urandom_range(0, 3))
            0: t[pos] = 8'($urandom_range(0, 255));
            1: begin
                case ($urandom_range(0, 2))
                    0:       pick = CH_COLON;
                    1:       pick = CH_DOT;
                    default: pick = 8'($urandom_range(0, 255));
                endcase
                t.insert(pos, pick);
            end
            2: if (t.size() > 1) t.delete(pos);
            default: begin
                t.push_back(CH_COLON);
                add_group(t);
            end
        endcase
        return t;
    endfunction

    function automatic t_text make_noise();
        t_text t;
        repeat ($urandom_range(1, 12)) t.push_back(8'($urandom_range(0, 255)));
        return t;
    endfunction

    // -----------------------------------------------------------------------
    // Stimulus
    // -----------------------------------------------------------------------
    initial begin
        t_text t;
        int    text_no;
        int    kind;

        sb = new();
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed: field extremes, leading zeros, foreign bytes, colon corner
        // cases, group counts and both unsupported family codes.
        send_text(FAM_V4, from_str("0.0.0.0"));
        send_text(FAM_V4, from_str("255.255.255.255"));
        send_text(FAM_V4, from_str("192.168.1.10"));
        send_text(FAM_V4, from_str("256.1.1.1"));
        send_text(FAM_V4, from_str("01.2.3.4"));
        send_text(FAM_V4, from_str("1.2.3"));
        send_text(FAM_V4, from_str("1.2.3.4.5"));
        send_text(FAM_V4, from_str("1..2.3"));
        t = from_str("1.2.3.4");
        t.insert(3, 8'h00);
        send_text(FAM_V4, t);
        send_text(FAM_V6, from_str("::"));
        send_text(FAM_V6, from_str("::1"));
        send_text(FAM_V6, from_str("1::"));
        send_text(FAM_V6, from_str("FFFF:ffff:0:0:0:0:AbCd:1234"));
        send_text(FAM_V6, from_str("1:2:3:4:5:6:7:8"));
        send_text(FAM_V6, from_str(":1:2:3:4:5:6:7:8"));
        send_text(FAM_V6, from_str("1:2:3:4:5:6:7:"));
        send_text(FAM_V6, from_str("1:::2"));
        send_text(FAM_V6, from_str("1::2::3"));
        send_text(FAM_V6, from_str("12345::"));
        send_text(FAM_V6, from_str("1:2:3:4:5:6:7:8:9"));
        send_text(FAM_V6, from_str("1::2:3:4:5:6:7:8"));
        send_text(FAM_V6, from_str("1.2::"));
        t = from_str("ab");
        t.push_back(8'hFF);
        send_text(FAM_V6, t);
        send_text(FAM_OTHER, from_str("abc"));
        send_text(FAM_SPARE, from_str("1.2.3.4"));

        // Random: mostly well-formed texts with random content, some broken,
        // some foreign families and raw noise.
        text_no = 0;
        while (counted_chars < CHAR_TARGET) begin
            quiet = (text_no % 10) >= 8;
            if (text_no == 10) drain_results();
            kind = $urandom_range(0, 19);
            if (kind <= 6) begin
                t = make_v4();
                if ($urandom_range(0, 3) == 0) t = mutate(t);
                send_text(FAM_V4, t);
            end else if (kind <= 14) begin
                t = make_v6();
                if ($urandom_range(0, 3) == 0) t = mutate(t);
                send_text(FAM_V6, t);
            end else if (kind <= 16) begin
                t = $urandom_range(0, 1) ? make_v4() : make_v6();
                send_text($urandom_range(0, 1) ? FAM_OTHER : FAM_SPARE, t);
            end else begin
                send_text(2'($urandom_range(0, 3)), make_noise());
            end
            text_no++;
        end
        quiet = 1'b0;

        // Wait out the last results, then let the pipeline settle.
        drain_results();
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        sb.close();
        if (sb.mismatches == 0) begin
            $display("[ip_address_text_parser] OK");
        end else begin
            $display("[ip_address_text_parser] ERROR");
        end
        $finish;
    end

endmodule

// ===== filelist.f =====
+incdir+rtl
rtl/ipap_pkg.sv
rtl/ip_address_text_parser.sv
sim/tb_top.sv
